/* rtl/core/kl_divergence_top1_compare_defines.svh */
// Assertion macros shared by the KL divergence block.
// No dependencies; the asserting modules expect clk and rst_n in scope.
`ifndef KL_DIVERGENCE_TOP1_COMPARE_DEFINES_SVH
`define KL_DIVERGENCE_TOP1_COMPARE_DEFINES_SVH
`ifndef SYNTHESIS
`define KLD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kldiv assertion failed");
`define KLD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kldiv assertion failed");
`else
`define KLD_ASSERT(label, prop)
`define KLD_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* rtl/core/kldiv_pkg.sv */
// Constants, types and the reciprocal table of the KL divergence block.
// Used by kldiv_mul, kldiv_engine and kl_divergence_top1_compare.
package kldiv_pkg;

    // Row and field geometry
    localparam int MAX_VOCAB   = 262144;
    localparam int CNT_W       = $clog2(MAX_VOCAB);
    localparam int IDX_OUT_W   = 18;
    localparam int LP_W        = 24;
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 20;
    localparam int KL_W        = 40;
    localparam int ACC_W       = 48;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 200;

    // Exponential evaluation in Q60
    localparam int QP           = 60;
    localparam int WORD_W       = 64;
    localparam int PROD_W       = 2 * WORD_W;
    localparam int HALF_W       = WORD_W / 2;
    localparam int EXP_FRAC     = 16;
    localparam int E_W          = EXP_FRAC + 1;
    localparam int EXP_CUTOFF   = 12;
    localparam int SERIES_TERMS = 24;
    localparam int K_W          = 5;
    localparam int IP_W         = 4;
    localparam int IP_IN_W      = LP_W - FRAC_BITS;

    // Per-element term
    localparam int DIFF_W = LP_W + 1;
    localparam int P_W    = DIFF_W + EXP_FRAC + 1;
    localparam int TERM_W = P_W - EXP_FRAC;

    localparam logic [WORD_W-1:0] Q_ONE        = WORD_W'(1) << QP;
    localparam logic [WORD_W-1:0] E_ONE        = WORD_W'(1) << EXP_FRAC;
    localparam logic [WORD_W-1:0] E_ROUND_HALF = WORD_W'(1) << (QP - EXP_FRAC - 1);
    localparam logic [P_W-1:0]    TERM_HALF    = P_W'(1) << (EXP_FRAC - 1);
    localparam logic [WORD_W-1:0] ALL_ONES     = '1;

    typedef enum logic [3:0] {
        EN_INIT,
        EN_IDLE,
        EN_SER_MUL,
        EN_SER_DIV,
        EN_SER_REM,
        EN_SER_ACC,
        EN_POW,
        EN_ROUND,
        EN_TERM
    } eng_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_COMMIT
    } top_state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic                   start;
        logic signed [LP_W-1:0] ref_lp;
        logic signed [LP_W-1:0] test_lp;
    } eng_req_t;

    typedef struct packed {
        logic                     ready;
        logic                     done;
        logic signed [TERM_W-1:0] term;
    } eng_rsp_t;

    // floor((2^64 - 1) / k); multiplying by it and keeping the top word
    // underestimates x / k by at most one
    function automatic logic [WORD_W-1:0] recip_k(input logic [K_W-1:0] k);
        logic [WORD_W-1:0] r;
        unique case (k)
            5'd2:    r = ALL_ONES / 64'd2;
            5'd3:    r = ALL_ONES / 64'd3;
            5'd4:    r = ALL_ONES / 64'd4;
            5'd5:    r = ALL_ONES / 64'd5;
            5'd6:    r = ALL_ONES / 64'd6;
            5'd7:    r = ALL_ONES / 64'd7;
            5'd8:    r = ALL_ONES / 64'd8;
            5'd9:    r = ALL_ONES / 64'd9;
            5'd10:   r = ALL_ONES / 64'd10;
            5'd11:   r = ALL_ONES / 64'd11;
            5'd12:   r = ALL_ONES / 64'd12;
            5'd13:   r = ALL_ONES / 64'd13;
            5'd14:   r = ALL_ONES / 64'd14;
            5'd15:   r = ALL_ONES / 64'd15;
            5'd16:   r = ALL_ONES / 64'd16;
            5'd17:   r = ALL_ONES / 64'd17;
            5'd18:   r = ALL_ONES / 64'd18;
            5'd19:   r = ALL_ONES / 64'd19;
            5'd20:   r = ALL_ONES / 64'd20;
            5'd21:   r = ALL_ONES / 64'd21;
            5'd22:   r = ALL_ONES / 64'd22;
            5'd23:   r = ALL_ONES / 64'd23;
            5'd24:   r = ALL_ONES / 64'd24;
            default: r = ALL_ONES;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/kldiv_mul.sv */
// Shared 64x64 multiplier: one 32x32 product per cycle, four partial
// products summed into a 128-bit register. Depends on kldiv_pkg.
module kldiv_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  kldiv_pkg::mul_req_t req,
    output kldiv_pkg::mul_rsp_t rsp
);
    import kldiv_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] pp_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [2:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [PROD_W-1:0] pp_ext;

    // Pick the halves for this step
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                mul_a = a_reg[HALF_W-1:0];
                mul_b = b_reg[HALF_W-1:0];
            end
            2'd1:
            begin
                mul_a = a_reg[HALF_W-1:0];
                mul_b = b_reg[WORD_W-1:HALF_W];
            end
            2'd2:
            begin
                mul_a = a_reg[WORD_W-1:HALF_W];
                mul_b = b_reg[HALF_W-1:0];
            end
            default:
            begin
                mul_a = a_reg[WORD_W-1:HALF_W];
                mul_b = b_reg[WORD_W-1:HALF_W];
            end
        endcase
    end

    // Align the partial product registered in the previous step
    always_comb
    begin
        unique case (step_reg)
            3'd1:       pp_ext = {{WORD_W{1'b0}}, pp_reg};
            3'd2, 3'd3: pp_ext = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            3'd4:       pp_ext = {pp_reg, {WORD_W{1'b0}}};
            default:    pp_ext = '0;
        endcase
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // Operands, partial product and running sum
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.op_a;
            b_reg   <= req.op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg  <= WORD_W'(mul_a) * WORD_W'(mul_b);
            acc_reg <= acc_reg + pp_ext;
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

/* rtl/core/kldiv_engine.sv */
// Sequencer computing one rounded KL term exp(ref) * (ref - test) on the
// shared multiplier. Depends on kldiv_pkg, kldiv_mul and the defines header.
`include "kl_divergence_top1_compare_defines.svh"

module kldiv_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  kldiv_pkg::eng_req_t req,
    output kldiv_pkg::eng_rsp_t rsp
);
    import kldiv_pkg::*;

    eng_state_t state_reg, state_next;
    logic                     init_reg, init_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [WORD_W-1:0]        term_reg, term_next;
    logic [WORD_W-1:0]        sum_reg, sum_next;
    logic [WORD_W-1:0]        f_reg, f_next;
    logic [WORD_W-1:0]        x_reg, x_next;
    logic [WORD_W-1:0]        q_reg, q_next;
    logic [WORD_W-1:0]        e1_reg, e1_next;
    logic [IP_W-1:0]          ip_reg, ip_next;
    logic [DIFF_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic signed [TERM_W-1:0] result_reg, result_next;
    logic                     done_reg, done_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    logic [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]  diff_mag;
    logic [LP_W-1:0]    abs_ref;
    logic [IP_IN_W-1:0] ip_in;
    logic [WORD_W-1:0]  frac_q;
    logic [WORD_W-1:0]  sum_upd;
    logic [WORD_W-1:0]  qmul_res;
    logic [WORD_W-1:0]  rem;
    logic [WORD_W-1:0]  e_sum;
    logic [E_W-1:0]     e_round;
    logic [P_W-1:0]     p_signed;
    logic [P_W-1:0]     p_round;

    kldiv_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Decode the incoming pair
    assign diff     = {req.ref_lp[LP_W-1], req.ref_lp} - {req.test_lp[LP_W-1], req.test_lp};
    assign diff_mag = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    assign abs_ref  = ~req.ref_lp + LP_W'(1);
    assign ip_in    = abs_ref[LP_W-1:FRAC_BITS];
    assign frac_q   = WORD_W'(abs_ref[FRAC_BITS-1:0]) << (QP - FRAC_BITS);

    // Product of two Q60 values, truncated back to Q60
    assign qmul_res = mrsp.product[QP+WORD_W-1:QP];
    assign rem      = x_reg - mrsp.product[WORD_W-1:0];

    // Alternating series update: odd terms subtract with floor at zero
    always_comb
    begin
        if (k_reg[0])
        begin
            sum_upd = (sum_reg >= term_reg) ? (sum_reg - term_reg) : '0;
        end
        else
        begin
            sum_upd = sum_reg + term_reg;
        end
    end

    // Round exp to Q1.16 and form the signed term
    assign e_sum    = sum_reg + E_ROUND_HALF;
    assign e_round  = e_sum[QP:QP-EXP_FRAC];
    assign p_signed = neg_reg ? (~{1'b0, mrsp.product[P_W-2:0]} + P_W'(1))
                              : {1'b0, mrsp.product[P_W-2:0]};
    assign p_round  = p_signed + TERM_HALF;

    // Next state and multiplier requests
    always_comb
    begin
        state_next  = state_reg;
        init_next   = init_reg;
        k_next      = k_reg;
        term_next   = term_reg;
        sum_next    = sum_reg;
        f_next      = f_reg;
        x_next      = x_reg;
        q_next      = q_reg;
        e1_next     = e1_reg;
        ip_next     = ip_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mreq.start  = 1'b0;
        mreq.op_a   = '0;
        mreq.op_b   = '0;

        unique case (state_reg)
            // Evaluate exp(-1) once after reset
            EN_INIT:
            begin
                term_next  = Q_ONE;
                sum_next   = Q_ONE;
                f_next     = Q_ONE;
                k_next     = K_W'(1);
                mreq.start = 1'b1;
                mreq.op_a  = Q_ONE;
                mreq.op_b  = Q_ONE;
                state_next = EN_SER_MUL;
            end
            EN_IDLE:
            begin
                if (req.start)
                begin
                    mag_next = diff_mag;
                    neg_next = diff[DIFF_W-1];
                    if (!req.ref_lp[LP_W-1])
                    begin
                        // exp saturates at one
                        mreq.start = 1'b1;
                        mreq.op_a  = WORD_W'(diff_mag);
                        mreq.op_b  = E_ONE;
                        state_next = EN_TERM;
                    end
                    else if (ip_in >= IP_IN_W'(EXP_CUTOFF))
                    begin
                        // exp underflows to zero
                        mreq.start = 1'b1;
                        mreq.op_a  = WORD_W'(diff_mag);
                        mreq.op_b  = '0;
                        state_next = EN_TERM;
                    end
                    else
                    begin
                        term_next  = Q_ONE;
                        sum_next   = Q_ONE;
                        f_next     = frac_q;
                        k_next     = K_W'(1);
                        ip_next    = IP_W'(ip_in);
                        mreq.start = 1'b1;
                        mreq.op_a  = Q_ONE;
                        mreq.op_b  = frac_q;
                        state_next = EN_SER_MUL;
                    end
                end
            end
            EN_SER_MUL:
            begin
                if (mrsp.done)
                begin
                    x_next     = qmul_res;
                    mreq.start = 1'b1;
                    mreq.op_a  = qmul_res;
                    mreq.op_b  = recip_k(k_reg);
                    state_next = EN_SER_DIV;
                end
            end
            EN_SER_DIV:
            begin
                if (mrsp.done)
                begin
                    q_next     = mrsp.product[PROD_W-1:WORD_W];
                    mreq.start = 1'b1;
                    mreq.op_a  = mrsp.product[PROD_W-1:WORD_W];
                    mreq.op_b  = WORD_W'(k_reg);
                    state_next = EN_SER_REM;
                end
            end
            EN_SER_REM:
            begin
                // Correct the quotient estimate by one where needed
                if (mrsp.done)
                begin
                    term_next  = (rem >= WORD_W'(k_reg)) ? (q_reg + WORD_W'(1)) : q_reg;
                    state_next = EN_SER_ACC;
                end
            end
            EN_SER_ACC:
            begin
                sum_next = sum_upd;
                if (k_reg == K_W'(SERIES_TERMS))
                begin
                    if (init_reg)
                    begin
                        e1_next    = sum_upd;
                        init_next  = 1'b0;
                        state_next = EN_IDLE;
                    end
                    else if (ip_reg == '0)
                    begin
                        state_next = EN_ROUND;
                    end
                    else
                    begin
                        mreq.start = 1'b1;
                        mreq.op_a  = sum_upd;
                        mreq.op_b  = e1_reg;
                        state_next = EN_POW;
                    end
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    mreq.start = 1'b1;
                    mreq.op_a  = term_reg;
                    mreq.op_b  = f_reg;
                    state_next = EN_SER_MUL;
                end
            end
            EN_POW:
            begin
                // Multiply by exp(-1) once per whole unit
                if (mrsp.done)
                begin
                    sum_next = qmul_res;
                    ip_next  = ip_reg - IP_W'(1);
                    if (ip_reg == IP_W'(1))
                    begin
                        state_next = EN_ROUND;
                    end
                    else
                    begin
                        mreq.start = 1'b1;
                        mreq.op_a  = qmul_res;
                        mreq.op_b  = e1_reg;
                    end
                end
            end
            EN_ROUND:
            begin
                mreq.start = 1'b1;
                mreq.op_a  = WORD_W'(mag_reg);
                mreq.op_b  = WORD_W'(e_round);
                state_next = EN_TERM;
            end
            EN_TERM:
            begin
                if (mrsp.done)
                begin
                    result_next = p_round[P_W-1:EXP_FRAC];
                    done_next   = 1'b1;
                    state_next  = EN_IDLE;
                end
            end
            default:
            begin
                state_next = EN_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EN_INIT;
            init_reg  <= 1'b1;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            ip_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
            ip_reg    <= ip_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        term_reg   <= term_next;
        sum_reg    <= sum_next;
        f_reg      <= f_next;
        x_reg      <= x_next;
        q_reg      <= q_next;
        e1_reg     <= e1_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign rsp.ready = (state_reg == EN_IDLE);
    assign rsp.done  = done_reg;
    assign rsp.term  = result_reg;

    `KLD_ASSERT(a_mul_free, mreq.start |-> !mrsp.busy)
    `KLD_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)
    `KLD_ASSERT(a_init_first, done_reg |-> !init_reg)

endmodule

/* rtl/core/kl_divergence_top1_compare.sv */
// KL divergence and top-1 agreement of a reference and a test log-prob row.
// Per element: one product when ref_logprob >= 0 or <= -12.0, otherwise 24 series steps of
// three products each, floor(-ref_logprob) exp(-1) products and a final product, on one 32x32 mul.
// The result beat is registered in the cycle after the last element's commit; s_axis_tready
// stays low while an element is in work. After rst_n deasserts an exp(-1)
// pass runs before the first beat can be taken.
`include "kl_divergence_top1_compare_defines.svh"

module kl_divergence_top1_compare (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [23:0] ref_logprob, [47:24] test_logprob, [67:48] row_position
    input  logic [kldiv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] row_is_tail
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [39:0] kl_value, [40] top1_match, [58:41] ref_top_index,
    // [76:59] test_top_index, [100:77] ref_at_ref_top, [124:101] test_at_ref_top,
    // [148:125] ref_at_test_top, [172:149] test_at_test_top, [192:173] out_position
    output logic [kldiv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] out_is_tail
    output logic                                  m_axis_tuser
);
    import kldiv_pkg::*;

    top_state_t state_reg, state_next;

    eng_req_t eng_req;
    eng_rsp_t eng_rsp;

    logic signed [LP_W-1:0]  ref_reg;
    logic signed [LP_W-1:0]  test_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    tail_reg;
    logic                    last_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        rbi_reg;
    logic [CNT_W-1:0]        tbi_reg;
    logic signed [LP_W-1:0]  rbv_reg;
    logic signed [LP_W-1:0]  tbv_reg;
    logic signed [LP_W-1:0]  tv_at_rb_reg;
    logic signed [LP_W-1:0]  rv_at_tb_reg;

    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic                    out_tail_reg;

    logic                    accept;
    logic                    commit;
    logic [ACC_W:0]          acc_sum;
    logic [ACC_W-1:0]        acc_sat;
    logic [KL_W-1:0]         kl_sat;
    logic                    first;
    logic                    ref_take;
    logic                    test_take;
    logic [CNT_W-1:0]        rbi_upd;
    logic [CNT_W-1:0]        tbi_upd;
    logic signed [LP_W-1:0]  rbv_upd;
    logic signed [LP_W-1:0]  tbv_upd;
    logic signed [LP_W-1:0]  tv_at_rb_upd;
    logic signed [LP_W-1:0]  rv_at_tb_upd;
    logic                    top1_match;
    logic [OUT_TDATA_W-1:0]  out_word;

    kldiv_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .rsp   (eng_rsp)
    );

    assign s_axis_tready = (state_reg == T_IDLE) && eng_rsp.ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign eng_req.start   = accept;
    assign eng_req.ref_lp  = s_axis_tdata[LP_W-1:0];
    assign eng_req.test_lp = s_axis_tdata[2*LP_W-1:LP_W];

    // Sequence: take a beat, wait for the term, commit when the output slot allows
    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_BUSY;
                end
            end
            T_BUSY:
            begin
                if (eng_rsp.done)
                begin
                    state_next = T_COMMIT;
                end
            end
            T_COMMIT:
            begin
                if (!last_reg || !out_valid_reg || m_axis_tready)
                begin
                    commit     = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Saturating accumulate of the signed term
    assign acc_sum = {acc_reg[ACC_W-1], acc_reg}
                   + {{(ACC_W + 1 - TERM_W){eng_rsp.term[TERM_W-1]}}, eng_rsp.term};

    always_comb
    begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // Clamp at zero and saturate to the output width
    always_comb
    begin
        if (acc_sat[ACC_W-1])
        begin
            kl_sat = '0;
        end
        else if (|acc_sat[ACC_W-2:KL_W])
        begin
            kl_sat = '1;
        end
        else
        begin
            kl_sat = acc_sat[KL_W-1:0];
        end
    end

    // First strict argmax of each row
    assign first     = (cnt_reg == '0);
    assign ref_take  = first || (ref_reg > rbv_reg);
    assign test_take = first || (test_reg > tbv_reg);

    assign rbi_upd      = ref_take  ? cnt_reg  : rbi_reg;
    assign rbv_upd      = ref_take  ? ref_reg  : rbv_reg;
    assign tv_at_rb_upd = ref_take  ? test_reg : tv_at_rb_reg;
    assign tbi_upd      = test_take ? cnt_reg  : tbi_reg;
    assign tbv_upd      = test_take ? test_reg : tbv_reg;
    assign rv_at_tb_upd = test_take ? ref_reg  : rv_at_tb_reg;
    assign top1_match   = (rbi_upd == tbi_upd);

    assign out_word = OUT_TDATA_W'({pos_reg, tbv_upd, rv_at_tb_upd, tv_at_rb_upd, rbv_upd,
                                    IDX_OUT_W'(tbi_upd), IDX_OUT_W'(rbi_upd), top1_match,
                                    kl_sat});

    // Sequencer state and output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Row state: advance on each commit, clear after the last element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            cnt_reg      <= '0;
            rbi_reg      <= '0;
            tbi_reg      <= '0;
            rbv_reg      <= '0;
            tbv_reg      <= '0;
            tv_at_rb_reg <= '0;
            rv_at_tb_reg <= '0;
        end
        else if (commit)
        begin
            if (last_reg)
            begin
                acc_reg      <= '0;
                cnt_reg      <= '0;
                rbi_reg      <= '0;
                tbi_reg      <= '0;
                rbv_reg      <= '0;
                tbv_reg      <= '0;
                tv_at_rb_reg <= '0;
                rv_at_tb_reg <= '0;
            end
            else
            begin
                acc_reg      <= acc_sat;
                rbi_reg      <= rbi_upd;
                tbi_reg      <= tbi_upd;
                rbv_reg      <= rbv_upd;
                tbv_reg      <= tbv_upd;
                tv_at_rb_reg <= tv_at_rb_upd;
                rv_at_tb_reg <= rv_at_tb_upd;
                if (cnt_reg != CNT_W'(MAX_VOCAB - 1))
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Hold the accepted beat and load the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ref_reg  <= s_axis_tdata[LP_W-1:0];
            test_reg <= s_axis_tdata[2*LP_W-1:LP_W];
            pos_reg  <= s_axis_tdata[2*LP_W+POS_W-1:2*LP_W];
            tail_reg <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
        if (commit && last_reg)
        begin
            out_data_reg <= out_word;
            out_tail_reg <= tail_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_tail_reg;

    `KLD_ASSERT(a_done_in_busy, eng_rsp.done |-> (state_reg == T_BUSY))
    `KLD_ASSERT_NEXT(a_last_emits, commit && last_reg, m_axis_tvalid)
    `KLD_ASSERT_NEXT(a_row_cleared, commit && last_reg, (cnt_reg == '0) && (acc_reg == '0))

endmodule
